/* hw/rtl/periodic_swing_foot_reference_unit_defines.svh */
// assertion macros for the swing foot reference block
`ifndef PERIODIC_SWING_FOOT_REFERENCE_UNIT_DEFINES_SVH
`define PERIODIC_SWING_FOOT_REFERENCE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define PSF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psf check failed");
`define PSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psf check failed");
`else
`define PSF_ASSERT_IMP(label, clk, rst, ante, cons)
`define PSF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/psf_pkg.sv */
package psf_pkg;

  // half-length first step select
  localparam logic FIRST_STEP_HALF = 1'b0;

  localparam int ACC_W  = 52;
  localparam int CFG_IW = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_START_X  = 3'd0,
    CFG_START_Z  = 3'd1,
    CFG_STRIDE   = 3'd2,
    CFG_LIFT     = 3'd3,
    CFG_FIRST    = 3'd4,
    CFG_LAST     = 3'd5,
    CFG_SWING    = 3'd6,
    CFG_STANCE   = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    STEP_WAIT,
    STEP_LOAD_RATE,
    STEP_DIV_RATE,
    STEP_SAVE_RATE,
    STEP_DIV_PHASE,
    STEP_SAVE_CYC,
    STEP_MUL_FRAC,
    STEP_MUL_CYC,
    STEP_MUL_TRI,
    STEP_SAVE_X,
    STEP_EMIT
  } step_t;

  typedef enum logic [1:0] {
    SEQ_GO,
    SEQ_WAIT_IN,
    SEQ_LOOP,
    SEQ_WAIT_OUT
  } seq_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD_RATE,
    DIV_LOAD_PHASE,
    DIV_STEP
  } div_op_t;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_FRAC_L,
    MUL_CYC_L,
    MUL_TRI_H
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_ADD,
    ACC_LOAD_X,
    ACC_LOAD_Z
  } acc_op_t;

  typedef enum logic [1:0] {
    ADD_NONE,
    ADD_FRAC,
    ADD_FULL,
    ADD_TRI
  } add_t;

  typedef struct packed {
    seq_t       seq;
    step_t      jmp;
    div_op_t    dv;
    logic [4:0] cnt_init;
    logic       save_rate;
    logic       save_cyc;
    mul_op_t    mul;
    acc_op_t    acc;
    add_t       add;
    logic       save_x;
  } ctrl_t;

  // microprogram rom
  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t w;
    w = '0;
    case (pc)
      STEP_WAIT: begin
        w.seq = SEQ_WAIT_IN;
        w.jmp = STEP_LOAD_RATE;
      end
      STEP_LOAD_RATE: begin
        w.jmp      = STEP_DIV_RATE;
        w.dv       = DIV_LOAD_RATE;
        w.cnt_init = 5'd23;
      end
      STEP_DIV_RATE: begin
        w.seq = SEQ_LOOP;
        w.jmp = STEP_SAVE_RATE;
        w.dv  = DIV_STEP;
      end
      STEP_SAVE_RATE: begin
        w.jmp       = STEP_DIV_PHASE;
        w.save_rate = 1'b1;
        w.dv        = DIV_LOAD_PHASE;
        w.cnt_init  = 5'd15;
      end
      STEP_DIV_PHASE: begin
        w.seq = SEQ_LOOP;
        w.jmp = STEP_SAVE_CYC;
        w.dv  = DIV_STEP;
      end
      STEP_SAVE_CYC: begin
        w.jmp      = STEP_MUL_FRAC;
        w.save_cyc = 1'b1;
        w.acc      = ACC_LOAD_X;
        w.add      = ADD_NONE;
      end
      STEP_MUL_FRAC: begin
        w.jmp = STEP_MUL_CYC;
        w.mul = MUL_FRAC_L;
      end
      STEP_MUL_CYC: begin
        w.jmp = STEP_MUL_TRI;
        w.mul = MUL_CYC_L;
        w.acc = ACC_ADD;
        w.add = ADD_FRAC;
      end
      STEP_MUL_TRI: begin
        w.jmp = STEP_SAVE_X;
        w.mul = MUL_TRI_H;
        w.acc = ACC_ADD;
        w.add = ADD_FULL;
      end
      STEP_SAVE_X: begin
        w.jmp    = STEP_EMIT;
        w.save_x = 1'b1;
        w.acc    = ACC_LOAD_Z;
        w.add    = ADD_TRI;
      end
      STEP_EMIT: begin
        w.seq = SEQ_WAIT_OUT;
        w.jmp = STEP_WAIT;
      end
      default: begin
        w.seq = SEQ_GO;
        w.jmp = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/psf_cfg_if.sv */
interface psf_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [psf_pkg::CFG_IW-1:0] index;
  logic [31:0]               data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

/* hw/rtl/psf_feed_if.sv */
interface psf_feed_if;
  logic        valid;
  logic        ready;
  logic [15:0] phase_index;
  logic [7:0]  grid_in_phase;
  logic [7:0]  grids_per_phase;

  modport source(output valid, output phase_index, output grid_in_phase,
                 output grids_per_phase, input ready);
  modport sink(input valid, input phase_index, input grid_in_phase,
               input grids_per_phase, output ready);
endinterface

/* hw/rtl/psf_result_if.sv */
interface psf_result_if;
  logic               valid;
  logic               ready;
  logic               active;
  logic signed [31:0] foot_x;
  logic signed [31:0] foot_z;

  modport source(output valid, output active, output foot_x, output foot_z,
                 input ready);
  modport sink(input valid, input active, input foot_x, input foot_z,
               output ready);
endinterface

/* hw/rtl/periodic_swing_foot_reference_unit.sv */
// periodic swing foot reference generator
// channels: cfg (register index + write data, always ready), feed (phase index,
// grid count, grid points per phase) and result (swing flag, forward position,
// height, both Q15.16 saturated). valid/ready on every channel.
// one word on feed gives exactly one word on result.
// the block takes no new feed word until the result of the last one has been
// loaded into the output register.
// the work is done by the shift-subtract divider, shared by both divisions
// (24 steps for the grid rate, 16 for the phase cycle), and then by the one
// multiplier and accumulator, all stepped by the microprogram.
// feed ready is high only while the sequencer waits at its first step.
// a result waiting in the output register holds until taken; the sequencer
// stalls at its last step until the register is free.
// reset (rst, synchronous) returns the sequencer to its wait step, empties
// the output register and sets the configuration registers to their defaults.
`include "periodic_swing_foot_reference_unit_defines.svh"

module periodic_swing_foot_reference_unit (
  input  logic         clk,
  input  logic         rst,
  psf_cfg_if.sink      cfg,
  psf_feed_if.sink     feed,
  psf_result_if.source result
);

  localparam int AW = psf_pkg::ACC_W;

  // configuration registers
  logic signed [31:0] start_x;
  logic signed [31:0] start_z;
  logic signed [31:0] stride_length;
  logic signed [31:0] lift_height;
  logic [15:0]        first_phase;
  logic [15:0]        last_phase;
  logic [15:0]        swing_phases;
  logic [15:0]        stance_phases;

  // sequencer
  psf_pkg::step_t pc;
  psf_pkg::step_t pc_next;
  psf_pkg::ctrl_t ctrl;
  logic [4:0]     cnt;

  // latched item
  logic [15:0] ph_r;
  logic [7:0]  grid_r;
  logic [7:0]  npts_r;

  // divider
  logic [16:0] div_rem;
  logic [23:0] div_quo;
  logic [16:0] div_dvs;
  logic [17:0] div_trial;
  logic [17:0] div_diff;
  logic        div_ge;

  logic [16:0] period;
  logic        period_nz;
  logic        ph_ge_first;
  logic [15:0] ph_off;

  logic [23:0] rate_r;
  logic [16:0] cyc_r;
  logic        act_r;

  // multiplier and accumulator
  logic signed [25:0]   mul_a;
  logic signed [31:0]   mul_b;
  logic signed [57:0]   prod;
  logic signed [57:0]   prod_sh;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_base;
  logic signed [AW-1:0] acc_sum;
  logic signed [31:0]   x_res;

  logic feed_fire;
  logic out_free;
  logic out_load;

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[AW-1:31];
    all_zero = ~|v[AW-1:31];
    if (all_one || all_zero) begin
      return v[31:0];
    end else if (v[AW-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  assign cfg.ready  = 1'b1;
  assign feed.ready = (pc == psf_pkg::STEP_WAIT);
  assign feed_fire  = feed.valid && feed.ready;
  assign out_free   = !result.valid || result.ready;
  assign out_load   = (ctrl.seq == psf_pkg::SEQ_WAIT_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x       <= '0;
      start_z       <= '0;
      stride_length <= '0;
      lift_height   <= '0;
      first_phase   <= '0;
      last_phase    <= 16'hffff;
      swing_phases  <= 16'd1;
      stance_phases <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (psf_pkg::cfg_idx_t'(cfg.index))
        psf_pkg::CFG_START_X: start_x       <= cfg.data;
        psf_pkg::CFG_START_Z: start_z       <= cfg.data;
        psf_pkg::CFG_STRIDE:  stride_length <= cfg.data;
        psf_pkg::CFG_LIFT:    lift_height   <= cfg.data;
        psf_pkg::CFG_FIRST:   first_phase   <= cfg.data[15:0];
        psf_pkg::CFG_LAST:    last_phase    <= cfg.data[15:0];
        psf_pkg::CFG_SWING:   swing_phases  <= cfg.data[15:0];
        psf_pkg::CFG_STANCE:  stance_phases <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // control word of the current step
  always_comb begin
    ctrl = psf_pkg::ucode(pc);
  end

  always_comb begin
    pc_next = pc;
    case (ctrl.seq)
      psf_pkg::SEQ_GO:       pc_next = ctrl.jmp;
      psf_pkg::SEQ_WAIT_IN:  if (feed_fire) pc_next = ctrl.jmp;
      psf_pkg::SEQ_LOOP:     if (cnt == '0) pc_next = ctrl.jmp;
      psf_pkg::SEQ_WAIT_OUT: if (out_free) pc_next = ctrl.jmp;
      default:               pc_next = psf_pkg::STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= psf_pkg::STEP_WAIT;
      cnt <= '0;
    end else begin
      pc <= pc_next;
      if (ctrl.dv == psf_pkg::DIV_LOAD_RATE || ctrl.dv == psf_pkg::DIV_LOAD_PHASE) begin
        cnt <= ctrl.cnt_init;
      end else if (ctrl.dv == psf_pkg::DIV_STEP && cnt != '0) begin
        cnt <= cnt - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (feed_fire) begin
      ph_r   <= feed.phase_index;
      grid_r <= feed.grid_in_phase;
      npts_r <= feed.grids_per_phase;
    end
  end

  assign period      = {1'b0, swing_phases} + {1'b0, stance_phases};
  assign period_nz   = (period != '0);
  assign ph_ge_first = (ph_r >= first_phase);
  assign ph_off      = ph_r - first_phase;

  // one restoring step per cycle
  assign div_trial = {div_rem, div_quo[23]};
  assign div_ge    = (div_trial >= {1'b0, div_dvs});
  assign div_diff  = div_trial - {1'b0, div_dvs};

  always_ff @(posedge clk) begin
    case (ctrl.dv)
      psf_pkg::DIV_LOAD_RATE: begin
        div_rem <= '0;
        div_quo <= {grid_r, 16'h0000};
        div_dvs <= {9'd0, npts_r};
      end
      psf_pkg::DIV_LOAD_PHASE: begin
        // phase offset sits in the top so 16 steps leave the quotient low
        div_rem <= '0;
        div_quo <= {ph_off, 8'h00};
        div_dvs <= period;
      end
      psf_pkg::DIV_STEP: begin
        div_rem <= div_ge ? div_diff[16:0] : div_trial[16:0];
        div_quo <= {div_quo[22:0], div_ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.save_rate) begin
      rate_r <= (npts_r == '0) ? '0 : div_quo;
    end
    if (ctrl.save_cyc) begin
      // remainder at or past the swing span means the cycle already rolled
      if (ph_ge_first && period_nz) begin
        cyc_r <= {1'b0, div_quo[15:0]} + 17'(div_rem >= {1'b0, swing_phases});
      end else begin
        cyc_r <= '0;
      end
      act_r <= ph_ge_first && (ph_r < last_phase) && period_nz &&
               (div_rem < {1'b0, swing_phases});
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = stride_length;
    case (ctrl.mul)
      psf_pkg::MUL_FRAC_L: begin
        if (psf_pkg::FIRST_STEP_HALF && cyc_r != '0) begin
          mul_a = $signed({2'b00, rate_r}) - 26'sd32768;
        end else begin
          mul_a = $signed({2'b00, rate_r});
        end
      end
      psf_pkg::MUL_CYC_L: mul_a = $signed({9'd0, cyc_r});
      psf_pkg::MUL_TRI_H: begin
        mul_b = lift_height;
        if (rate_r < 24'd32768) begin
          mul_a = $signed({2'b00, rate_r});
        end else begin
          mul_a = 26'sd65536 - $signed({2'b00, rate_r});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul != psf_pkg::MUL_IDLE) begin
      prod <= mul_a * mul_b;
    end
  end

  always_comb begin
    case (ctrl.add)
      psf_pkg::ADD_FRAC: begin
        if (psf_pkg::FIRST_STEP_HALF && cyc_r == '0) begin
          prod_sh = prod >>> 17;
        end else begin
          prod_sh = prod >>> 16;
        end
      end
      psf_pkg::ADD_FULL: prod_sh = prod;
      psf_pkg::ADD_TRI:  prod_sh = prod >>> 15;
      default:           prod_sh = '0;
    endcase
    case (ctrl.acc)
      psf_pkg::ACC_LOAD_X: acc_base = AW'(start_x);
      psf_pkg::ACC_LOAD_Z: acc_base = AW'(start_z);
      default:             acc_base = acc;
    endcase
    acc_sum = acc_base + $signed(prod_sh[AW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc != psf_pkg::ACC_HOLD) begin
      acc <= acc_sum;
    end
    if (ctrl.save_x) begin
      x_res <= sat32(acc);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.active <= act_r;
      result.foot_x <= x_res;
      result.foot_z <= sat32(acc);
    end
  end

  `PSF_ASSERT_NEXT(a_accept_starts, clk, rst, feed_fire, pc == psf_pkg::STEP_LOAD_RATE)
  `PSF_ASSERT_IMP(a_no_overwrite, clk, rst, result.valid && !result.ready, !out_load)
  `PSF_ASSERT_IMP(a_rem_bound, clk, rst, pc == psf_pkg::STEP_SAVE_CYC && period_nz, div_rem < period)
  `PSF_ASSERT_IMP(a_act_range, clk, rst, out_load && act_r, ph_r >= first_phase && ph_r < last_phase)

endmodule

/* verif/swing_foot_checker.sv */
`timescale 1ns / 100ps

module swing_foot_checker (
  input  logic  clk,
  input  logic  rst,
  psf_cfg_if    cfg,
  psf_feed_if   feed,
  psf_result_if result,
  output int    errors,
  output int    checked,
  output int    swings,
  output int    pending
);

  typedef struct {
    logic               active;
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_z;
  } foot_ref_t;

  // shadow of the register file, tracked from the cfg channel
  logic signed [31:0] start_x_r;
  logic signed [31:0] start_z_r;
  logic signed [31:0] stride_r;
  logic signed [31:0] lift_r;
  logic [15:0]        first_r;
  logic [15:0]        last_r;
  logic [15:0]        swing_r;
  logic [15:0]        stance_r;

  foot_ref_t foot_ref_q[$];

  task automatic flag_error(input string msg);
    if (errors < 100) $display("%0t swing foot check: %s", $time, msg);
    errors++;
  endtask

  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic foot_ref_t predict_foot(input logic [15:0] ph, input logic [7:0] cnt,
                                             input logic [7:0] pts);
    foot_ref_t r;
    longint    p;
    longint    first;
    longint    swing;
    longint    period;
    longint    rate;
    longint    len;
    longint    hgt;
    longint    cyc;
    longint    frac;
    longint    x;
    longint    z;
    p      = ph;
    first  = first_r;
    swing  = swing_r;
    period = swing + longint'(stance_r);
    len    = stride_r;
    hgt    = lift_r;
    // grid rate in Q8.16, may exceed one when the count runs past the points
    rate = (pts == 0) ? 0 : (longint'(cnt) << 16) / longint'(pts);

    cyc = 0;
    if (period != 0 && p >= first + swing) cyc = (p - first - swing) / period + 1;

    if (cyc == 0) begin
      x = psf_pkg::FIRST_STEP_HALF ? (rate * len) >>> 17 : (rate * len) >>> 16;
    end else begin
      frac = psf_pkg::FIRST_STEP_HALF ? rate - 32768 : rate;
      x = cyc * len + ((frac * len) >>> 16);
    end
    x = x + longint'(start_x_r);

    // triangle: rising over the first half of the rate, falling after
    if (rate < 32768) z = (rate * hgt) >>> 15;
    else z = ((65536 - rate) * hgt) >>> 15;
    z = z + longint'(start_z_r);

    r.active = 1'b0;
    if (period != 0 && p >= first && p < longint'(last_r)) begin
      if ((p - first) % period < swing) r.active = 1'b1;
    end
    r.foot_x = clamp_q16(x);
    r.foot_z = clamp_q16(z);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    foot_ref_t want;
    if (rst) begin
      start_x_r = '0;
      start_z_r = '0;
      stride_r  = '0;
      lift_r    = '0;
      first_r   = 16'd0;
      last_r    = 16'hffff;
      swing_r   = 16'd1;
      stance_r  = 16'd0;
      errors    = 0;
      checked   = 0;
      swings    = 0;
      foot_ref_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (psf_pkg::cfg_idx_t'(cfg.index))
          psf_pkg::CFG_START_X: start_x_r = cfg.data;
          psf_pkg::CFG_START_Z: start_z_r = cfg.data;
          psf_pkg::CFG_STRIDE:  stride_r  = cfg.data;
          psf_pkg::CFG_LIFT:    lift_r    = cfg.data;
          psf_pkg::CFG_FIRST:   first_r   = cfg.data[15:0];
          psf_pkg::CFG_LAST:    last_r    = cfg.data[15:0];
          psf_pkg::CFG_SWING:   swing_r   = cfg.data[15:0];
          psf_pkg::CFG_STANCE:  stance_r  = cfg.data[15:0];
          default: ;
        endcase
      end
      // retire before queueing so a fresh step never pairs with a result
      if (result.valid && result.ready) begin
        if (foot_ref_q.size() == 0) begin
          flag_error($sformatf("result word %0d with no step waiting", checked));
        end else begin
          want = foot_ref_q.pop_front();
          if (result.active !== want.active)
            flag_error($sformatf("word %0d active %b, expected %b", checked,
                                 result.active, want.active));
          if (result.foot_x !== want.foot_x)
            flag_error($sformatf("word %0d foot_x %0d, expected %0d", checked,
                                 result.foot_x, want.foot_x));
          if (result.foot_z !== want.foot_z)
            flag_error($sformatf("word %0d foot_z %0d, expected %0d", checked,
                                 result.foot_z, want.foot_z));
          if (want.active) swings++;
        end
        checked++;
      end
      if (feed.valid && feed.ready)
        foot_ref_q.push_back(predict_foot(feed.phase_index, feed.grid_in_phase,
                                          feed.grids_per_phase));
    end
    pending <= foot_ref_q.size();
  end

endmodule

/* verif/tb_periodic_swing_foot_reference_unit.sv */
`timescale 1ns / 100ps

module tb_periodic_swing_foot_reference_unit;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_SETS = 14;
  localparam int SET_STEPS   = 125;

  typedef enum int {
    SET_TYPICAL,
    SET_HIGH,
    SET_LOW,
    SET_SATURATE,
    SET_RAW
  } setting_kind_t;

  logic clk = 1'b0;
  logic rst;

  psf_cfg_if    cfg();
  psf_feed_if   feed();
  psf_result_if result();

  int errors;
  int checked;
  int swings;
  int pending;

  int steps_sent;
  int settings_loaded;
  int quiet;
  int stall_left;
  bit tx_idle;
  bit rx_idle;

  // register values last written, used only to aim the stimulus
  int cur_first;
  int cur_swing;
  int cur_stance;

  periodic_swing_foot_reference_unit dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .feed   (feed),
    .result (result)
  );

  swing_foot_checker foot_check (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .feed    (feed),
    .result  (result),
    .errors  (errors),
    .checked (checked),
    .swings  (swings),
    .pending (pending)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 70);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      result.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      result.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (cfg.valid && cfg.ready) || (feed.valid && feed.ready) ||
        (result.valid && result.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("no word moved for %0d cycles, %0d results still due", quiet, pending);
      $display("tb_periodic_swing_foot_reference_unit: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input psf_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic config_all(input logic [31:0] sx, input logic [31:0] sz,
                            input logic [31:0] sl, input logic [31:0] lh,
                            input logic [15:0] fp, input logic [15:0] lp,
                            input logic [15:0] sw, input logic [15:0] st);
    write_reg(psf_pkg::CFG_START_X, sx);
    write_reg(psf_pkg::CFG_START_Z, sz);
    write_reg(psf_pkg::CFG_STRIDE, sl);
    write_reg(psf_pkg::CFG_LIFT, lh);
    write_reg(psf_pkg::CFG_FIRST, {16'h0, fp});
    write_reg(psf_pkg::CFG_LAST, {16'h0, lp});
    write_reg(psf_pkg::CFG_SWING, {16'h0, sw});
    write_reg(psf_pkg::CFG_STANCE, {16'h0, st});
    cfg.valid <= 1'b0;
    cur_first  = fp;
    cur_swing  = sw;
    cur_stance = st;
    settings_loaded++;
  endtask

  task automatic send_step(input logic [15:0] ph, input logic [7:0] cnt, input logic [7:0] pts);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      feed.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    feed.valid           <= 1'b1;
    feed.phase_index     <= ph;
    feed.grid_in_phase   <= cnt;
    feed.grids_per_phase <= pts;
    do @(posedge clk); while (!feed.ready);
    steps_sent++;
  endtask

  // pending follows the handshakes only at a clock edge, so look only after an edge
  task automatic drain();
    feed.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_step();
    int         roll;
    longint     span;
    longint     ph;
    logic [7:0] pts;
    logic [7:0] cnt;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      pts  = (roll < 40) ? 8'($urandom_range(1, 16)) : 8'($urandom_range(1, 255));
      cnt  = 8'($urandom_range(0, pts));
      span = (longint'(cur_swing) + cur_stance) * 12 + cur_swing + 8;
      ph   = cur_first + longint'($urandom_range(0, 32'(span))) - 4;
      if (ph < 0) ph = 0;
      if (ph > 65535) ph = 65535;
      send_step(ph[15:0], cnt, pts);
    end else begin
      // noise: any phase, counts past the points, zero points
      send_step(16'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic pick_settings(input setting_kind_t kind);
    logic [31:0] sx;
    logic [31:0] sz;
    logic [31:0] sl;
    logic [31:0] lh;
    int          fp;
    int          lp;
    int          sw;
    int          st;
    case (kind)
      SET_HIGH: config_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           16'hffff, 16'hffff, 16'hffff, 16'hffff);
      SET_LOW: config_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                          16'h0, 16'h0, 16'h0, 16'h0);
      SET_SATURATE: begin
        sx = $urandom_range(0, 1) ? 32'h7fff0000 : 32'h80010000;
        sz = $urandom_range(0, 1) ? 32'h7fff0000 : 32'h80010000;
        sl = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        lh = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        config_all(sx, sz, sl, lh, 16'h0, 16'hffff, 16'd1, 16'($urandom_range(0, 2)));
      end
      SET_RAW: config_all($urandom, $urandom, $urandom, $urandom,
                          16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      default: begin
        sx = $urandom_range(0, 2097152) - 1048576;
        sz = $urandom_range(0, 262144) - 131072;
        sl = $urandom_range(0, 524288) - 262144;
        lh = $urandom_range(0, 131072) - 65536;
        fp = $urandom_range(0, 300);
        sw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        st = (sw == 0 && $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 12);
        lp = ($urandom_range(0, 4) == 0) ? 65535 : fp + $urandom_range(0, 2000);
        config_all(sx, sz, sl, lh, 16'(fp), 16'(lp), 16'(sw), 16'(st));
      end
    endcase
  endtask

  initial begin
    setting_kind_t kind;
    int            roll;
    rst                  <= 1'b1;
    cfg.valid            <= 1'b0;
    cfg.index            <= psf_pkg::CFG_START_X;
    cfg.data             <= '0;
    feed.valid           <= 1'b0;
    feed.phase_index     <= '0;
    feed.grid_in_phase   <= '0;
    feed.grids_per_phase <= '0;
    rx_idle              <= 1'b1;
    tx_idle         = 1'b1;
    steps_sent      = 0;
    settings_loaded = 0;
    cur_first       = 0;
    cur_swing       = 1;
    cur_stance      = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset defaults first
    send_step(16'd0, 8'd0, 8'd1);
    send_step(16'd100, 8'd128, 8'd255);
    send_step(16'hffff, 8'd255, 8'd255);
    drain();

    // period of five: three swing, two stance, stepping over phases 4..39
    config_all(32'h00010000, 32'h00004000, 32'h00008000, 32'h00002000,
               16'd4, 16'd40, 16'd3, 16'd2);
    send_step(16'd0, 8'd3, 8'd6);       // before start
    send_step(16'd4, 8'd0, 8'd10);
    send_step(16'd4, 8'd5, 8'd10);      // triangle peak
    send_step(16'd6, 8'd10, 8'd10);
    send_step(16'd7, 8'd1, 8'd3);       // stance of the first full cycle
    send_step(16'd9, 8'd2, 8'd7);
    send_step(16'd39, 8'd7, 8'd8);
    send_step(16'd40, 8'd7, 8'd8);      // end is exclusive
    send_step(16'd12, 8'd255, 8'd1);    // count far beyond points
    send_step(16'd13, 8'd200, 8'd0);    // zero points
    send_step(16'hffff, 8'd255, 8'd255);
    send_step(16'd20, 8'd0, 8'd255);
    drain();

    // empty period
    config_all(32'h00010000, 32'h00004000, 32'h00008000, 32'h00002000,
               16'd4, 16'd40, 16'd0, 16'd0);
    send_step(16'd50, 8'd1, 8'd2);
    send_step(16'd0, 8'd0, 8'd1);
    drain();

    // no swing phases, cycles counted by stance
    config_all(32'h00010000, 32'h00004000, 32'h00008000, 32'h00002000,
               16'd4, 16'd40, 16'd0, 16'd5);
    send_step(16'd10, 8'd3, 8'd4);
    send_step(16'd3, 8'd3, 8'd4);
    drain();

    config_all(32'h7fff0000, 32'h80000000, 32'h7fffffff, 32'h80000000,
               16'd0, 16'hffff, 16'd1, 16'd0);
    send_step(16'hffff, 8'd255, 8'd1);
    send_step(16'd0, 8'd255, 8'd128);

    for (int set_no = 0; set_no < RANDOM_SETS; set_no++) begin
      drain();
      tx_idle = (set_no % 4) != 3;
      rx_idle <= (set_no % 5) != 4;
      roll = $urandom_range(0, 9);
      case (set_no)
        0:       kind = SET_HIGH;
        1:       kind = SET_LOW;
        2:       kind = SET_SATURATE;
        3:       kind = SET_RAW;
        default: kind = (roll < 6) ? SET_TYPICAL : (roll < 8) ? SET_RAW : SET_SATURATE;
      endcase
      pick_settings(kind);
      repeat (SET_STEPS) random_step();
    end

    drain();
    repeat (64) @(posedge clk);
    $display("swing foot reference: %0d steps under %0d register settings", steps_sent,
             settings_loaded);
    $display("%0d result words compared, %0d of them in swing", checked, swings);
    if (errors == 0) begin
      $display("tb_periodic_swing_foot_reference_unit: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_periodic_swing_foot_reference_unit: errors");
    end
    $finish;
  end

endmodule
